@@ design/hsi2rgb_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the cosine ratio table of the HSI to RGB converter.
// No dependencies; every other design file refers to this package by scoped names.
package hsi2rgb_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int HUE_BITS = 9;
  localparam int HP_BITS = 7;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SATURATION = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_INTENSITY = 2'd1;

  localparam logic [HUE_BITS-1:0] HUE_WRAP = 9'd360;
  localparam logic [HUE_BITS-1:0] SECTOR_SPAN = 9'd120;
  localparam logic [HUE_BITS-1:0] SECTOR2_START = 9'd240;
  localparam int SECTOR_ANGLES = 120;
  localparam int HALF_SECTOR = 60;

  localparam int ANG_BITS = 28;
  localparam int RATIO_BITS = 31;
  localparam int COS_TERMS = 12;
  localparam longint unsigned PI_Q28 = 64'd843314857;
  localparam longint unsigned DEG_HALF_TURN = 64'd180;

  typedef enum logic [1:0] {
    SEC_RG = 2'd0,
    SEC_GB = 2'd1,
    SEC_BR = 2'd2
  } sector_t;

  typedef logic signed [RATIO_BITS-1:0] ratio_t;
  typedef ratio_t ratio_table_t [SECTOR_ANGLES];

  // Long division by shift and subtract, used only while the table is built.
  function automatic longint unsigned div_u64(input longint unsigned n,
                                              input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Cosine of a whole-degree angle in signed Q.28, from a truncated Taylor series.
  function automatic longint cos_q28(input int unsigned deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    x = div_u64(64'(deg) * PI_Q28, DEG_HALF_TURN);
    x2 = (x * x) >> ANG_BITS;
    term = 64'd1 << ANG_BITS;
    sum = longint'(term);
    for (int k = 1; k <= COS_TERMS; k++) begin
      term = div_u64((term * x2) >> ANG_BITS, 64'((2 * k - 1) * (2 * k)));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    return sum;
  endfunction

  // cos(hp) / cos(|60 - hp|) in signed Q.28 for every reduced hue of a sector.
  function automatic ratio_table_t build_ratio_table();
    ratio_table_t tbl;
    longint num;
    longint den;
    longint unsigned mag;
    longint unsigned quot;
    int unsigned dd;
    for (int h = 0; h < SECTOR_ANGLES; h++) begin
      dd = (h <= HALF_SECTOR) ? int'(HALF_SECTOR - h) : int'(h - HALF_SECTOR);
      num = cos_q28(h) * (64'sd1 <<< ANG_BITS);
      den = cos_q28(dd);
      if (den <= 0) begin
        den = 1;
      end
      // The quotient is truncated toward zero.
      mag = (num < 0) ? longint'(-num) : longint'(num);
      quot = div_u64(mag, longint'(den));
      tbl[h] = (num < 0) ? RATIO_BITS'(-longint'(quot)) : RATIO_BITS'(longint'(quot));
    end
    return tbl;
  endfunction

  localparam ratio_table_t RATIO_TABLE = build_ratio_table();

endpackage

@@ design/hsi2rgb_cfg.sv @@
`timescale 1ns / 1ps
// Saturation and intensity registers with their clamp to 1.0.
// Depends on hsi2rgb_pkg for register indexes.
module hsi2rgb_cfg #(
  parameter int FRAC_BITS = hsi2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [hsi2rgb_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [FRAC_BITS:0]                    wr_data,
  output logic [FRAC_BITS:0]                    sat,
  output logic [FRAC_BITS:0]                    inten
);

  localparam int CW = FRAC_BITS + 1;
  localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [CW-1:0] saturation;
  logic [CW-1:0] intensity;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation <= ONE;
      intensity <= ONE;
    end else if (wr_en) begin
      unique case (wr_index)
        hsi2rgb_pkg::REG_SATURATION: saturation <= wr_data;
        hsi2rgb_pkg::REG_INTENSITY:  intensity <= wr_data;
        default: ;
      endcase
    end
  end

  assign sat = (saturation > ONE) ? ONE : saturation;
  assign inten = (intensity > ONE) ? ONE : intensity;

endmodule

@@ design/hsi2rgb_rdiv.sv @@
`timescale 1ns / 1ps
// Three-stage rounding divider: quo = round(prod / (3 * 2^FRAC_BITS)), ties up.
// Uses a reciprocal multiply by 1/3 with one correction step; depends on hsi2rgb_pkg.
module hsi2rgb_rdiv #(
  parameter int FRAC_BITS = hsi2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic [2:0]               en,
  input  logic [2*FRAC_BITS+2:0]   prod,
  output logic [FRAC_BITS+1:0]     quo
);

  localparam int PW = 2 * FRAC_BITS + 3;
  localparam int VW = FRAC_BITS + 2;
  localparam int MW = 2 * FRAC_BITS + 4;
  localparam logic [PW:0] BIAS = (PW + 1)'(64'd3 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0] RECIP = (FRAC_BITS + 1)'((64'd1 << VW) / 3);
  localparam logic [VW-1:0] THREE = VW'(3);

  logic [PW:0]    biased;
  logic [VW-1:0]  v_a;
  logic [MW-1:0]  scaled;
  logic [VW-1:0]  v_b;
  logic [VW-1:0]  q0_b;
  logic [VW-1:0]  rem;

  // Dividing by 2^FRAC_BITS first is exact for the floor, leaving a divide by three.
  assign biased = {1'b0, prod} + BIAS;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v_a <= biased[FRAC_BITS +: VW];
    end
  end

  assign scaled = v_a * RECIP;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      v_b <= v_a;
      q0_b <= scaled[VW +: VW];
    end
  end

  // The estimate is never high and at most one low.
  assign rem = v_b - THREE * q0_b;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      quo <= (rem >= THREE) ? q0_b + VW'(1) : q0_b;
    end
  end

endmodule

@@ design/hsi_to_rgb_converter_core.sv @@
`timescale 1ns / 1ps
// Converts one hue per clock, while the output side accepts, into red, green and blue in
// unsigned Q1.FRAC_BITS, using the three-sector HSI formula with saturation and intensity
// from two configuration registers (index 0 saturation, index 1 intensity, both reset to
// 1.0 and clamped to 1.0 on use). The datapath is a nine-stage pipeline: a new hue word is
// taken every cycle when the output side never stalls. The stage count is set by the
// chain of multiplies (saturation times table ratio, intensity times the result) and the
// two divide-by-three units. Each stage holds its word under backpressure while emptier
// stages behind it keep filling. There is no reset sweep; the block is ready as soon as
// reset has cleared the valid flags. Depends on hsi2rgb_pkg, hsi2rgb_cfg and hsi2rgb_rdiv.
module hsi_to_rgb_converter_core #(
  parameter int FRAC_BITS = hsi2rgb_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hsi2rgb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [FRAC_BITS:0]                    cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [hsi2rgb_pkg::HUE_BITS-1:0]      hue_deg,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [FRAC_BITS:0]                    red,
  output logic [FRAC_BITS:0]                    green,
  output logic [FRAC_BITS:0]                    blue
);

  localparam int NS = 9;
  localparam int CW = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;
  localparam int PW = 2 * FRAC_BITS + 3;
  localparam int RW = hsi2rgb_pkg::RATIO_BITS;
  localparam int ANG = hsi2rgb_pkg::ANG_BITS;
  localparam int SRW = CW + 1 + RW;
  localparam int TW = SRW + 1;
  localparam int HB = hsi2rgb_pkg::HUE_BITS;
  localparam int HPB = hsi2rgb_pkg::HP_BITS;
  localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [TW-1:0] T_ONE = TW'(1) <<< (FRAC_BITS + ANG);
  localparam logic [TW-1:0] T_HALF = TW'(1) << (ANG - 1);

  logic [CW-1:0] sat;
  logic [CW-1:0] inten;

  logic [NS:1] vld;
  logic [NS:1] rdy;
  hsi2rgb_pkg::sector_t sec [1:NS];

  // Stage 1 signals.
  logic [HB-1:0]          hue_w;
  hsi2rgb_pkg::sector_t   sec_in;
  logic [HPB-1:0]         hp_in;
  logic [PW-1:0]          lowprod_in;
  logic [HPB-1:0]         hp1;
  logic [PW-1:0]          lowprod1;
  // Stages 2 to 5.
  hsi2rgb_pkg::ratio_t    ratio2;
  logic signed [CW:0]     sat_s;
  logic signed [SRW-1:0]  sr_in;
  logic signed [SRW-1:0]  sr3;
  logic signed [TW-1:0]   t_sum;
  logic [TW-1:0]          t_pos;
  logic [TW-1:0]          t_rnd;
  logic [UW-1:0]          u4;
  logic [UW-1:0]          low_q;
  logic [PW-1:0]          hprod_in;
  logic [PW-1:0]          hprod5;
  logic [CW-1:0]          lowp [5:8];
  // Stage 9.
  logic [UW-1:0]          high_q;
  logic [CW-1:0]          high_c;
  logic signed [CW+1:0]   rest_s;
  logic [CW-1:0]          rest_c;
  logic [CW-1:0]          low8;

  hsi2rgb_cfg #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .sat      (sat),
    .inten    (inten)
  );

  assign cfg_ready = 1'b1;

  // A stage can load when it is empty or the stage ahead of it is moving.
  assign rdy = ~vld | {out_ready, rdy[NS:2]};
  assign in_ready = rdy[1];
  assign out_valid = vld[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      sec[1] <= sec_in;
    end
    for (int k = 2; k <= NS; k++) begin
      if (rdy[k]) begin
        sec[k] <= sec[k-1];
      end
    end
  end

  // Stage 1: wrap the hue, find its sector and the angle within it, and form i * (1 - s).
  assign hue_w = (hue_deg >= hsi2rgb_pkg::HUE_WRAP) ? hue_deg - hsi2rgb_pkg::HUE_WRAP : hue_deg;

  always_comb begin
    priority if (hue_w < hsi2rgb_pkg::SECTOR_SPAN) begin
      sec_in = hsi2rgb_pkg::SEC_RG;
      hp_in = hue_w[HPB-1:0];
    end else if (hue_w < hsi2rgb_pkg::SECTOR2_START) begin
      sec_in = hsi2rgb_pkg::SEC_GB;
      hp_in = HPB'(hue_w - hsi2rgb_pkg::SECTOR_SPAN);
    end else begin
      sec_in = hsi2rgb_pkg::SEC_BR;
      hp_in = HPB'(hue_w - hsi2rgb_pkg::SECTOR2_START);
    end
  end

  assign lowprod_in = inten * (ONE - sat);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hp1 <= hp_in;
      lowprod1 <= lowprod_in;
    end
  end

  // Stages 2 to 4 of the low channel: round(i * (1 - s) / 3).
  hsi2rgb_rdiv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_low_div (
    .clk  (clk),
    .en   (rdy[4:2]),
    .prod (lowprod1),
    .quo  (low_q)
  );

  // Stage 2: table lookup of cos(hp) / cos(60 - hp).
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ratio2 <= hsi2rgb_pkg::RATIO_TABLE[hp1];
    end
  end

  // Stage 3: scale the ratio by saturation.
  assign sat_s = $signed({1'b0, sat});
  assign sr_in = sat_s * ratio2;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      sr3 <= sr_in;
    end
  end

  // Stage 4: u = round(1 + s * ratio), floored at zero.
  assign t_sum = T_ONE + TW'(sr3);
  assign t_pos = t_sum[TW-1] ? '0 : t_sum;
  assign t_rnd = t_pos + T_HALF;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      u4 <= t_rnd[ANG +: UW];
    end
  end

  // Stage 5: intensity times u, and the low channel clamped.
  assign hprod_in = inten * u4;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      hprod5 <= hprod_in;
      lowp[5] <= (low_q > UW'(ONE)) ? ONE : low_q[CW-1:0];
    end
    for (int k = 6; k <= 8; k++) begin
      if (rdy[k]) begin
        lowp[k] <= lowp[k-1];
      end
    end
  end

  // Stages 6 to 8 of the high channel: round(i * u / 3).
  hsi2rgb_rdiv #(
    .FRAC_BITS(FRAC_BITS)
  ) u_high_div (
    .clk  (clk),
    .en   (rdy[8:6]),
    .prod (hprod5),
    .quo  (high_q)
  );

  // Stage 9: the remaining channel and placement by sector.
  assign low8 = lowp[8];
  assign high_c = (high_q > UW'(ONE)) ? ONE : high_q[CW-1:0];
  assign rest_s = $signed({2'b00, inten}) - $signed({2'b00, low8}) - $signed({2'b00, high_c});

  always_comb begin
    priority if (rest_s < 0) begin
      rest_c = '0;
    end else if (rest_s > $signed({2'b00, ONE})) begin
      rest_c = ONE;
    end else begin
      rest_c = rest_s[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      unique case (sec[8])
        hsi2rgb_pkg::SEC_RG: begin
          red <= high_c;
          green <= rest_c;
          blue <= low8;
        end
        hsi2rgb_pkg::SEC_GB: begin
          red <= low8;
          green <= high_c;
          blue <= rest_c;
        end
        hsi2rgb_pkg::SEC_BR: begin
          red <= rest_c;
          green <= low8;
          blue <= high_c;
        end
        default: begin
          red <= '0;
          green <= '0;
          blue <= '0;
        end
      endcase
    end
  end

  ap_hp_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> ({2'b00, hp1} < hsi2rgb_pkg::SECTOR_SPAN))
    else $error("reduced hue outside its sector");

  ap_low_range: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> (lowp[5] <= ONE))
    else $error("low channel above one");

  ap_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= ONE && green <= ONE && blue <= ONE))
    else $error("color word outside 0..1");

  ap_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[1])
    else $error("accepted hue word did not enter the pipeline");

  ap_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[NS] && !out_ready && vld[NS-1]) |=> (vld[NS] && vld[NS-1]))
    else $error("stalled words dropped inside the pipeline");

endmodule
